// ===== rtl/dbdm_pkg.sv =====
// Package for the dual-button debounce and message block.
// Holds message codes, the reset value and the per-button debouncer state type.
// No dependencies.
`default_nettype none

package dbdm_pkg;

	// Message codes carried in button_code
	localparam logic [2:0] CODE_NONE  = 3'd0;
	localparam logic [2:0] CODE_LATCH = 3'd3;
	localparam logic [2:0] CODE_ON    = 3'd4;
	localparam logic [2:0] CODE_OFF   = 3'd5;

	// Counter width and saturation value of the debouncers
	localparam int unsigned CNT_W = 8;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Reset value of the debounce_ticks register
	localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 8'd20;

	// Per-button debouncer state
	typedef struct packed {
		logic             raw_last;
		logic [CNT_W-1:0] count;
		logic             level;
	} deb_t;

endpackage

`default_nettype wire

// ===== rtl/dual_button_debounce_message_fsm.sv =====
// Top level of the dual-button debounce and message block.
// Two stable-count debouncers, edge detection and the mode/message logic.
// Depends on dbdm_pkg.
//
//   channel   | direction | handshake               | payload
//   ----------+-----------+-------------------------+---------------------------------
//   s_axis    | in        | s_axis_tvalid/tready    | tdata: mode_raw, action_raw
//   m_axis    | out       | m_axis_tvalid/tready    | tdata: forced_off_send,
//             |           |                         |   button_send, button_code[2:0],
//             |           |                         |   momentary_mode
//   cfg       | in        | cfg_valid/cfg_ready     | cfg_data: debounce_ticks
//
// One sample tick per transfer; a new tick is taken every cycle unless a stalled
// output register holds its result, which blocks input only while m_axis_tready
// is low. The debouncer and message logic sit between the input port and the
// output register, so a result appears in the cycle after its tick. arst_n
// returns the block to momentary mode with released buttons and debounce_ticks = 20.
`default_nettype none

module dual_button_debounce_message_fsm (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// Sample input
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,  // [0] mode_raw, [1] action_raw, [7:2] zero
	// Result output
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic      [7:0] m_axis_tdata,  // [0] forced_off_send, [1] button_send,
	                                       // [4:2] button_code, [5] momentary_mode,
	                                       // [7:6] zero
	// Configuration write
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_data       // debounce_ticks
);

	// Debounce one button: restart on change, saturate on repeat, qualify level
	function automatic dbdm_pkg::deb_t deb_step(
		input dbdm_pkg::deb_t                  cur,
		input logic                            raw,
		input logic [dbdm_pkg::CNT_W-1:0]      ticks
	);
		dbdm_pkg::deb_t nxt;
		nxt = cur;
		if (raw != cur.raw_last) begin
			nxt.raw_last = raw;
			nxt.count    = '0;
		end else if (cur.count != dbdm_pkg::CNT_MAX) begin
			nxt.count = cur.count + 1'b1;
		end
		if (nxt.count >= ticks) begin
			nxt.level = nxt.raw_last;
		end
		return nxt;
	endfunction

	logic [dbdm_pkg::CNT_W-1:0] ticks_q;
	dbdm_pkg::deb_t             mode_deb_q, action_deb_q;
	dbdm_pkg::deb_t             mode_deb_n, action_deb_n;
	logic                       mode_prev_q, action_prev_q;
	logic                       mode_flag_q, mode_flag_n;
	logic [2:0]                 last_code_q, last_code_n;
	logic                       out_valid_q;
	logic [7:0]                 out_data_q;

	logic       in_fire, out_fire;
	logic       mode_press, act_press, act_release;
	logic       forced_n, sent_n;
	logic [2:0] code_n, last_mid;

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_fire = out_valid_q && m_axis_tready;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign cfg_ready     = 1'b1;

	// Debounce, detect edges, toggle mode and pick the message
	always_comb begin
		mode_deb_n   = deb_step(mode_deb_q, s_axis_tdata[0], ticks_q);
		action_deb_n = deb_step(action_deb_q, s_axis_tdata[1], ticks_q);

		mode_press  = !mode_deb_n.level && mode_prev_q;
		mode_flag_n = mode_flag_q ^ mode_press;
		forced_n    = mode_press && (last_code_q == dbdm_pkg::CODE_LATCH);
		last_mid    = forced_n ? dbdm_pkg::CODE_OFF : last_code_q;

		act_press   = !action_deb_n.level && action_prev_q;
		act_release = action_deb_n.level && !action_prev_q;

		sent_n = 1'b0;
		code_n = dbdm_pkg::CODE_NONE;
		if (mode_flag_n) begin
			if (act_press) begin
				sent_n = 1'b1;
				code_n = dbdm_pkg::CODE_ON;
			end else if (act_release) begin
				sent_n = 1'b1;
				code_n = dbdm_pkg::CODE_OFF;
			end
		end else if (act_press) begin
			sent_n = 1'b1;
			code_n = dbdm_pkg::CODE_LATCH;
		end
		last_code_n = sent_n ? code_n : last_mid;
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= dbdm_pkg::DEBOUNCE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			ticks_q <= cfg_data;
		end
	end

	// Advance button and mode state on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_deb_q    <= '{raw_last: 1'b1, count: '0, level: 1'b1};
			action_deb_q  <= '{raw_last: 1'b1, count: '0, level: 1'b1};
			mode_prev_q   <= 1'b0;
			action_prev_q <= 1'b0;
			mode_flag_q   <= 1'b1;
			last_code_q   <= dbdm_pkg::CODE_ON;
		end else if (in_fire) begin
			mode_deb_q    <= mode_deb_n;
			action_deb_q  <= action_deb_n;
			mode_prev_q   <= mode_deb_n.level;
			action_prev_q <= action_deb_n.level;
			mode_flag_q   <= mode_flag_n;
			last_code_q   <= last_code_n;
		end
	end

	// Output register: load on accept, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_data_q <= {2'b00, mode_flag_n, code_n, sent_n, forced_n};
		end
	end

	// A forced OFF only ever comes with a mode toggle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && forced_n |-> mode_flag_n != mode_flag_q)
		else $error("forced OFF without mode toggle");

	// Held code is always a real message code
	assert property (@(posedge clk) disable iff (!arst_n)
		last_code_q == dbdm_pkg::CODE_LATCH || last_code_q == dbdm_pkg::CODE_ON ||
		last_code_q == dbdm_pkg::CODE_OFF)
		else $error("last code out of set");

	// No message means a zero code in the result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_data_q[1] |-> out_data_q[4:2] == dbdm_pkg::CODE_NONE)
		else $error("code without send");

	// A LATCH message only appears in latch mode
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q[4:2] == dbdm_pkg::CODE_LATCH |-> !out_data_q[5])
		else $error("LATCH in momentary mode");

	// Stable counter steps by one, restarts at zero or stays saturated
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> mode_deb_q.count == '0 ||
			mode_deb_q.count == $past(mode_deb_q.count) + 1'b1 ||
			mode_deb_q.count == dbdm_pkg::CNT_MAX)
		else $error("mode counter jumped");

endmodule

`default_nettype wire

// ===== tb/tb_dual_button_debounce_message_fsm.sv =====
// Self-checking bench for dual_button_debounce_message_fsm: button samples are streamed in,
// each message result is checked against an in-bench copy of the debounce and mode logic.
// Depends on dbdm_pkg and the top-level RTL.

module tb_dual_button_debounce_message_fsm;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;

	// One expected result transfer
	typedef struct packed {
		bit         forced_off;
		bit         sent;
		logic [2:0] code;
		bit         momentary;
	} msg_result_t;

	// Mirror of both debouncers and the mode/message logic, plus the results still owed
	class debounced_messages;
		bit [dbdm_pkg::CNT_W-1:0] ticks;
		bit                       mode_flag;
		logic [2:0]               last_code;
		bit                       mode_prev;
		bit                       action_prev;
		dbdm_pkg::deb_t           mode_deb;
		dbdm_pkg::deb_t           action_deb;
		msg_result_t              owed_msgs[$];
		int                       errors;

		function new();
			ticks       = dbdm_pkg::DEBOUNCE_RESET;
			mode_flag   = 1'b1;
			last_code   = dbdm_pkg::CODE_ON;
			mode_prev   = 1'b0;
			action_prev = 1'b0;
			mode_deb    = '{raw_last: 1'b1, count: '0, level: 1'b1};
			action_deb  = '{raw_last: 1'b1, count: '0, level: 1'b1};
			errors      = 0;
		endfunction

		function void set_ticks(input bit [dbdm_pkg::CNT_W-1:0] value);
			ticks = value;
		endfunction

		function int pending();
			return owed_msgs.size();
		endfunction

		// Restart the count on a change, else count up to saturation; accept when stable
		function void advance_debouncer(input bit raw, inout dbdm_pkg::deb_t d);
			if (raw != d.raw_last) begin
				d.raw_last = raw;
				d.count    = '0;
			end else if (d.count != dbdm_pkg::CNT_MAX) begin
				d.count = d.count + 1'b1;
			end
			if (d.count >= ticks)
				d.level = d.raw_last;
		endfunction

		// Work out the message caused by one accepted sample tick
		function void take_sample(input bit mode_raw, input bit action_raw);
			msg_result_t r;
			bit          press;
			bit          rel;
			r = '0;
			advance_debouncer(mode_raw, mode_deb);
			if (!mode_deb.level && mode_prev) begin
				mode_flag = ~mode_flag;
				if (last_code == dbdm_pkg::CODE_LATCH) begin
					last_code    = dbdm_pkg::CODE_OFF;
					r.forced_off = 1'b1;
				end
			end
			advance_debouncer(action_raw, action_deb);
			press = !action_deb.level && action_prev;
			rel   = action_deb.level && !action_prev;
			r.code = dbdm_pkg::CODE_NONE;
			if (mode_flag) begin
				if (press) begin
					r.code = dbdm_pkg::CODE_ON;
					r.sent = 1'b1;
				end else if (rel) begin
					r.code = dbdm_pkg::CODE_OFF;
					r.sent = 1'b1;
				end
			end else if (press) begin
				r.code = dbdm_pkg::CODE_LATCH;
				r.sent = 1'b1;
			end
			if (r.sent)
				last_code = r.code;
			mode_prev   = mode_deb.level;
			action_prev = action_deb.level;
			r.momentary = mode_flag;
			owed_msgs.push_back(r);
		endfunction

		// Compare one result transfer with the oldest owed message
		function void match_result(input logic [7:0] data);
			msg_result_t want;
			if (owed_msgs.size() == 0) begin
				$error("result 0x%02h arrived with no sample tick waiting for it", data);
				errors++;
				return;
			end
			want = owed_msgs.pop_front();
			if (data[0] !== want.forced_off) begin
				$error("forced_off_send: expected %0d, got %0d", want.forced_off, data[0]);
				errors++;
			end
			if (data[1] !== want.sent) begin
				$error("button_send: expected %0d, got %0d", want.sent, data[1]);
				errors++;
			end
			if (data[4:2] !== want.code) begin
				$error("button_code: expected %0d, got %0d", want.code, data[4:2]);
				errors++;
			end
			if (data[5] !== want.momentary) begin
				$error("momentary_mode: expected %0d, got %0d", want.momentary, data[5]);
				errors++;
			end
		endfunction
	endclass

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata  = '0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic       cfg_valid     = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data      = '0;

	debounced_messages msgs = new();

	bit tx_steady   = 1'b0;
	bit rx_steady   = 1'b0;
	bit rx_hold_req = 1'b0;
	int cycles      = 0;

	dual_button_debounce_message_fsm u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_dual_button_debounce_message_fsm failed");
			$finish;
		end
	end

	// Check every result transfer; values are stable at the falling edge before it lands
	always @(negedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			msgs.match_result(m_axis_tdata);
	end

	// Drive result-side ready: short and long stalls, one long hold-off on request
	initial begin : result_sink
		int stall_left;
		int hold_left;
		int pick;
		stall_left = 0;
		hold_left  = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				hold_left   = 150;
				rx_hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (rx_steady) begin
				m_axis_tready <= 1'b1;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 65) begin
					m_axis_tready <= 1'b1;
				end else begin
					stall_left = (pick < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
					m_axis_tready <= 1'b0;
				end
			end
		end
	end

	function automatic int pick_gap();
		int pick;
		if (tx_steady)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		if (pick < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Offer one sample tick and hold it until the transfer; valid stays high afterwards
	task automatic send_sample(input bit mode_raw, input bit action_raw);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'b0, action_raw, mode_raw};
		do @(negedge clk); while (!s_axis_tready);
		msgs.take_sample(mode_raw, action_raw);
		@(posedge clk);
	endtask

	// Stop offering and wait until every owed message has come back
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (msgs.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_debounce_ticks(input bit [7:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(negedge clk); while (!cfg_ready);
		msgs.set_ticks(value);
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random button activity: mostly holds long enough to settle, some short bursts,
	// and bounce on the first samples of each hold
	task automatic run_button_phase(input bit [7:0] ticks, input int n_items,
	                                input bit long_hold, input bit steady);
		int done;
		int seg_len;
		bit tm;
		bit ta;
		bit m;
		bit a;
		drain_results();
		write_debounce_ticks(ticks);
		tx_steady = steady;
		rx_steady = steady;
		if (long_hold)
			rx_hold_req = 1'b1;
		done = 0;
		while (done < n_items) begin
			tm = $urandom_range(0, 1);
			ta = $urandom_range(0, 1);
			if ($urandom_range(0, 9) < 7)
				seg_len = int'(ticks) + 1 + $urandom_range(0, 4);
			else
				seg_len = $urandom_range(1, int'(ticks) + 1);
			for (int i = 0; i < seg_len; i++) begin
				m = tm;
				a = ta;
				if (i < 3 && $urandom_range(0, 3) == 0)
					m = ~m;
				if (i < 3 && $urandom_range(0, 3) == 0)
					a = ~a;
				send_sample(m, a);
				done++;
			end
		end
	endtask

	// Directed walk at zero debounce: {action_raw, mode_raw} per tick
	bit [1:0] edge_walk [14] = '{
		2'b11, 2'b01, 2'b00, 2'b11, 2'b01, 2'b10, 2'b01,
		2'b00, 2'b11, 2'b01, 2'b00, 2'b11, 2'b00, 2'b11
	};

	initial begin : stimulus
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setting: first tick sees a release edge, press settles after 21 ticks
		repeat (21) send_sample(1'b1, 1'b0);

		// Zero debounce: every edge, mode toggles, latch, forced off with a button message
		drain_results();
		write_debounce_ticks(8'd0);
		foreach (edge_walk[k])
			send_sample(edge_walk[k][0], edge_walk[k][1]);

		// Largest setting: both presses settle together once the counters saturate
		drain_results();
		write_debounce_ticks(8'd255);
		repeat (260) send_sample(1'b0, 1'b0);

		run_button_phase(8'd1, 70, 1'b1, 1'b0);
		run_button_phase(8'd0, 60, 1'b0, 1'b0);
		run_button_phase(8'd2, 60, 1'b0, 1'b1);
		run_button_phase(8'($urandom_range(3, 12)), 60, 1'b0, 1'b0);
		run_button_phase(8'($urandom_range(3, 12)), 60, 1'b1, 1'b0);
		run_button_phase(8'($urandom_range(3, 12)), 60, 1'b0, 1'b0);
		run_button_phase(dbdm_pkg::DEBOUNCE_RESET, 70, 1'b0, 1'b0);
		run_button_phase(8'd1, 60, 1'b0, 1'b0);

		// Let the last results land, then keep waiting for strays
		drain_results();
		repeat (5) @(posedge clk);
		if (msgs.errors == 0 && msgs.pending() == 0)
			$display("tb_dual_button_debounce_message_fsm passed");
		else
			$display("tb_dual_button_debounce_message_fsm failed");
		$finish;
	end

endmodule
